>>> rtl/splice_site_region_classifier_unit_defines.svh
// ----------------------------------------------------------------------------
// Splice-site region classifier: assertion macros
// Concurrent check wrappers; they expand to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef SPLICE_SITE_REGION_CLASSIFIER_UNIT_DEFINES_SVH
`define SPLICE_SITE_REGION_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define SSRC_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ssrc assertion failed");
// Next-cycle implication, disabled during reset
`define SSRC_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ssrc assertion failed");
`else
`define SSRC_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SSRC_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/ssrc_pkg.sv
// ----------------------------------------------------------------------------
// Splice-site region classifier: package
// Shared constants, codes and the token that walks the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package ssrc_pkg;

  // Sizing
  localparam int SSRC_MAX_EXONS_DEF = 64;
  localparam int POS_W              = 31;
  localparam int CNT_W              = 7;
  localparam int SLOT_W             = 6;
  localparam int KIND_W             = 2;

  // Input item mode codes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Region kind codes
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXON   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INTRON = 2'd2;

  // Configuration register indexes
  localparam logic CFG_STRAND = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  // Query token: position, context and the first exon / intron hits so far
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] n;
    logic             fwd;
    logic             ex_hit;
    logic [CNT_W-1:0] ex_num;
    logic             ex_acc;
    logic             ex_don;
    logic             it_hit;
    logic [CNT_W-1:0] it_num;
    logic             it_acc;
    logic             it_don;
  } tok_t;

endpackage

`default_nettype wire

>>> rtl/splice_site_region_classifier_unit.sv
// ----------------------------------------------------------------------------
// Splice-site region classifier: top level
// Exon table spread over a chain of cells, one slot per cell; a query token
// walks the chain and collects the first exon and intron hits.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_ready   mode, entry_index/start/end, position
// out_     output     out_valid/out_ready kind, number, acceptor, donor
// cfg_     input      cfg_valid/cfg_ready index, data (0 strand, 1 exon count)
//
// A load transaction writes its cell and yields no result.
// A query launches a token that passes through the cells of the chain in
// order, from cell 0 to the last cell, where its result is registered.
// One query is in flight at a time; the input stays closed until its token
// leaves the last cell. A stalled output holds the last cell.
// Reset clears control, sets the strand to forward and the count to zero; no table clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "splice_site_region_classifier_unit_defines.svh"

module splice_site_region_classifier_unit
  import ssrc_pkg::*;
#(
  parameter int MAX_EXONS = SSRC_MAX_EXONS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic              in_mode,
  input  wire logic [SLOT_W-1:0] in_entry_index,
  input  wire logic [POS_W-1:0]  in_entry_start,
  input  wire logic [POS_W-1:0]  in_entry_end,
  input  wire logic [POS_W-1:0]  in_query_position,
  // result channel
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [KIND_W-1:0] out_region_kind,
  output      logic [CNT_W-1:0]  out_region_number,
  output      logic              out_splice_acceptor,
  output      logic              out_splice_donor,
  // configuration channel
  input  wire logic              cfg_valid,
  output      logic              cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [CNT_W-1:0]  cfg_data
);

  logic             strand_fwd_r;
  logic [CNT_W-1:0] count_r;
  logic             busy_r;
  logic             out_valid_r;
  logic [KIND_W-1:0] kind_r;
  logic [CNT_W-1:0] num_r;
  logic             acc_r, don_r;

  logic             in_acc, load_en, launch, adv, last_vld;
  logic [CNT_W-1:0] n_clamp;
  tok_t             tok_launch, tok_last;

  logic [MAX_EXONS-1:0] vld_vec;
  tok_t                 tok_vec   [MAX_EXONS];
  logic [POS_W-1:0]     start_vec [MAX_EXONS];

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strand_fwd_r <= 1'b1;
      count_r      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STRAND: strand_fwd_r <= cfg_data[0];
        CFG_COUNT:  count_r      <= cfg_data;
        default:    count_r      <= count_r;
      endcase
    end
  end

  // Input side: loads go straight to their cell, queries launch a token
  assign in_ready = !busy_r;
  assign in_acc   = in_valid && in_ready;
  assign load_en  = in_acc && (in_mode == MODE_LOAD);
  assign launch   = in_acc && (in_mode == MODE_QUERY);

  assign n_clamp = (32'(count_r) > 32'(MAX_EXONS)) ? CNT_W'(MAX_EXONS) : count_r;

  always_comb begin
    tok_launch        = '0;
    tok_launch.pos    = in_query_position;
    tok_launch.n      = n_clamp;
    tok_launch.fwd    = strand_fwd_r;
  end

  // Chain advances unless the last cell holds a token the output cannot take
  assign last_vld = vld_vec[MAX_EXONS-1];
  assign tok_last = tok_vec[MAX_EXONS-1];
  assign adv      = !(last_vld && out_valid_r && !out_ready);

  // Cell chain
  for (genvar i = 0; i < MAX_EXONS; i++) begin : g_cell
    logic [POS_W-1:0] nstart;
    logic             vin;
    tok_t             tin;

    if (i == MAX_EXONS - 1) begin : g_tail
      assign nstart = '0;
    end else begin : g_mid
      assign nstart = start_vec[i+1];
    end

    if (i == 0) begin : g_head
      assign vin = launch;
      assign tin = tok_launch;
    end else begin : g_body
      assign vin = vld_vec[i-1];
      assign tin = tok_vec[i-1];
    end

    ssrc_cell #(
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .load_en    (load_en),
      .load_index (in_entry_index),
      .load_start (in_entry_start),
      .load_end   (in_entry_end),
      .next_start (nstart),
      .start_q    (start_vec[i]),
      .adv        (adv),
      .vld_in     (vin),
      .tok_in     (tin),
      .vld_q      (vld_vec[i]),
      .tok_q      (tok_vec[i])
    );
  end

  // Busy while a query token is in the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (launch) begin
      busy_r <= 1'b1;
    end else if (last_vld && adv) begin
      busy_r <= 1'b0;
    end
  end

  // Output register: exon hit wins over intron hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (last_vld && adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_vld && adv) begin
      if (tok_last.ex_hit) begin
        kind_r <= KIND_EXON;
        num_r  <= tok_last.ex_num;
        acc_r  <= tok_last.ex_acc;
        don_r  <= tok_last.ex_don;
      end else if (tok_last.it_hit) begin
        kind_r <= KIND_INTRON;
        num_r  <= tok_last.it_num;
        acc_r  <= tok_last.it_acc;
        don_r  <= tok_last.it_don;
      end else begin
        kind_r <= KIND_NONE;
        num_r  <= '0;
        acc_r  <= 1'b0;
        don_r  <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_region_kind     = kind_r;
  assign out_region_number   = num_r;
  assign out_splice_acceptor = acc_r;
  assign out_splice_donor    = don_r;

  // Checks
  `SSRC_ASSERT_IMP(a_one_token, clk, rst_n, 1'b1, $onehot0(vld_vec))
  `SSRC_ASSERT_IMP(a_busy_match, clk, rst_n, 1'b1, busy_r == (|vld_vec))
  `SSRC_ASSERT_NXT(a_launch_head, clk, rst_n, launch, vld_vec[0])
  `SSRC_ASSERT_IMP(a_result_src, clk, rst_n, $rose(out_valid_r), $past(last_vld))

endmodule

`default_nettype wire

>>> rtl/ssrc_cell.sv
// ----------------------------------------------------------------------------
// Splice-site region classifier: chain cell
// Holds one exon slot, checks the passing token against exon IDX and intron
// IDX, and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ssrc_cell
  import ssrc_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // slot load
  input  wire logic              load_en,
  input  wire logic [SLOT_W-1:0] load_index,
  input  wire logic [POS_W-1:0]  load_start,
  input  wire logic [POS_W-1:0]  load_end,
  // neighbor slot start (start of exon IDX+1)
  input  wire logic [POS_W-1:0]  next_start,
  output      logic [POS_W-1:0]  start_q,
  // token chain
  input  wire logic              adv,
  input  wire logic              vld_in,
  input  wire tok_t              tok_in,
  output      logic              vld_q,
  output      tok_t              tok_q
);

  logic [POS_W-1:0] start_r, end_r;
  logic             vld_r;
  tok_t             tok_r, tok_nxt;

  logic [31:0] idx_w, n_w, p_w, s_w, e_w, ns_w;
  logic        first, last, exon_ok, intron_ok, ex_in, it_in;
  logic        near_start, near_end;

  // Slot storage; unwritten slots hold whatever they power up with
  always_ff @(posedge clk) begin
    if (load_en && ({26'd0, load_index} == 32'(IDX))) begin
      start_r <= load_start;
      end_r   <= load_end;
    end
  end

  // Match logic for exon IDX and intron IDX
  always_comb begin
    idx_w      = 32'(IDX);
    n_w        = {25'd0, tok_in.n};
    p_w        = {1'b0, tok_in.pos};
    s_w        = {1'b0, start_r};
    e_w        = {1'b0, end_r};
    ns_w       = {1'b0, next_start};
    first      = (idx_w == 32'd0);
    last       = ((idx_w + 32'd1) == n_w);
    exon_ok    = (idx_w < n_w);
    intron_ok  = ((idx_w + 32'd1) < n_w);
    ex_in      = exon_ok && (s_w <= p_w) && (p_w < e_w);
    it_in      = intron_ok && (e_w <= p_w) && (p_w < ns_w);
    near_start = (p_w == e_w) || (p_w == e_w + 32'd1);
    near_end   = (p_w + 32'd1 == ns_w) || (p_w + 32'd2 == ns_w);

    tok_nxt = tok_in;
    if (!tok_in.ex_hit && ex_in) begin
      tok_nxt.ex_hit = 1'b1;
      if (tok_in.fwd) begin
        tok_nxt.ex_num = CNT_W'(idx_w + 32'd1);
        tok_nxt.ex_acc = !first && (p_w == s_w);
        tok_nxt.ex_don = !last && ((p_w + 32'd1 == e_w) || (p_w + 32'd2 == e_w) ||
                                   (p_w + 32'd3 == e_w));
      end else begin
        tok_nxt.ex_num = CNT_W'(n_w - idx_w);
        tok_nxt.ex_acc = !last && (p_w + 32'd1 == e_w);
        tok_nxt.ex_don = !first && ((p_w == s_w) || (p_w == s_w + 32'd1) ||
                                    (p_w == s_w + 32'd2));
      end
    end
    if (!tok_in.it_hit && it_in) begin
      tok_nxt.it_hit = 1'b1;
      if (tok_in.fwd) begin
        tok_nxt.it_num = CNT_W'(idx_w + 32'd1);
        tok_nxt.it_acc = near_end;
        tok_nxt.it_don = near_start;
      end else begin
        tok_nxt.it_num = CNT_W'(n_w - 32'd1 - idx_w);
        tok_nxt.it_acc = near_start;
        tok_nxt.it_don = near_end;
      end
    end
  end

  // Token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign start_q = start_r;
  assign vld_q   = vld_r;
  assign tok_q   = tok_r;

endmodule

`default_nettype wire

>>> sim/splice_site_region_classifier_unit_test.sv
// ----------------------------------------------------------------------------
// Splice-site region classifier: testbench
// Loads exon tables and classifies query positions against them. An in-bench
// classifier predicts region kind, number and splice flags for every accepted
// query. The scoreboard checks each result against the oldest prediction,
// under random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module splice_site_region_classifier_unit_test;
  import ssrc_pkg::*;

  localparam int TABLE_DEPTH    = SSRC_MAX_EXONS_DEF;
  localparam int SETTLE_CYCLES  = TABLE_DEPTH + 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 1000;

  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  exon_first;
    logic [POS_W-1:0]  exon_end;
    logic [POS_W-1:0]  position;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CNT_W-1:0]  number;
    logic              acceptor;
    logic              donor;
  } region_t;

  // DUT ports, all inputs known from time zero
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_mode = MODE_LOAD;
  logic [SLOT_W-1:0] in_entry_index = '0;
  logic [POS_W-1:0]  in_entry_start = '0;
  logic [POS_W-1:0]  in_entry_end = '0;
  logic [POS_W-1:0]  in_query_position = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [KIND_W-1:0] out_region_kind;
  logic [CNT_W-1:0]  out_region_number;
  logic              out_splice_acceptor;
  logic              out_splice_donor;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = CFG_STRAND;
  logic [CNT_W-1:0]  cfg_data = '0;

  // Predictor state
  logic [POS_W-1:0] exon_start_mem [TABLE_DEPTH];
  logic [POS_W-1:0] exon_end_mem [TABLE_DEPTH];
  logic             strand_fwd = 1'b1;
  logic [CNT_W-1:0] exon_num = '0;

  // Stimulus and scoreboard bookkeeping
  item_t            pending_q [$];
  region_t          region_expect_q [$];
  logic [POS_W-1:0] gene_first [TABLE_DEPTH];
  logic [POS_W-1:0] gene_end [TABLE_DEPTH];
  int               in_sent_cnt = 0;
  int               in_done_cnt = 0;
  int               in_idle = 0;
  int               out_hold = 0;
  int               idle_cycles = 0;
  int               err_cnt = 0;
  int               items_made = 0;
  bit               calm = 1'b0;

  splice_site_region_classifier_unit DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_entry_index      (in_entry_index),
    .in_entry_start      (in_entry_start),
    .in_entry_end        (in_entry_end),
    .in_query_position   (in_query_position),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_region_kind     (out_region_kind),
    .out_region_number   (out_region_number),
    .out_splice_acceptor (out_splice_acceptor),
    .out_splice_donor    (out_splice_donor),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Classify one position against the current table and strand
  function automatic region_t classify_position(input logic [POS_W-1:0] pos);
    region_t     r;
    int          n;
    logic [32:0] p, s, e;
    r = '0;
    n = (exon_num > TABLE_DEPTH) ? TABLE_DEPTH : exon_num;
    p = {2'b00, pos};
    // exons first, lowest slot wins
    for (int i = 0; i < n; i++) begin
      s = {2'b00, exon_start_mem[i]};
      e = {2'b00, exon_end_mem[i]};
      if (r.kind == KIND_NONE && s <= p && p < e) begin
        r.kind = KIND_EXON;
        r.number = CNT_W'(strand_fwd ? i + 1 : n - i);
        if (strand_fwd) begin
          r.acceptor = (i != 0) && (p == s);
          r.donor = (i != n - 1) && (p + 1 == e || p + 2 == e || p + 3 == e);
        end else begin
          r.acceptor = (i != n - 1) && (p + 1 == e);
          r.donor = (i != 0) && (p == s || p == s + 1 || p == s + 2);
        end
      end
    end
    // then introns between neighboring slots
    for (int i = 0; i + 1 < n; i++) begin
      s = {2'b00, exon_end_mem[i]};
      e = {2'b00, exon_start_mem[i + 1]};
      if (r.kind == KIND_NONE && s <= p && p < e) begin
        r.kind = KIND_INTRON;
        r.number = CNT_W'(strand_fwd ? i + 1 : n - 1 - i);
        r.acceptor = strand_fwd ? (p + 1 == e || p + 2 == e) : (p == s || p == s + 1);
        r.donor = strand_fwd ? (p == s || p == s + 1) : (p + 1 == e || p + 2 == e);
      end
    end
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none in calm stretches
  function automatic int gap_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_load(input int slot, input logic [POS_W-1:0] first,
                                    input logic [POS_W-1:0] last);
    item_t it;
    it.mode = MODE_LOAD;
    it.slot = SLOT_W'(slot);
    it.exon_first = first;
    it.exon_end = last;
    it.position = POS_W'($urandom);
    pending_q.insert(pending_q.size(), it);
    items_made++;
  endfunction

  function automatic void push_query(input logic [POS_W-1:0] pos);
    item_t it;
    it.mode = MODE_QUERY;
    it.slot = SLOT_W'($urandom);
    it.exon_first = POS_W'($urandom);
    it.exon_end = POS_W'($urandom);
    it.position = pos;
    pending_q.insert(pending_q.size(), it);
    items_made++;
  endfunction

  // Build a gene of n exons: mostly ordered, with empty, inverted and
  // overlapping exons mixed in
  function automatic void plan_gene(input int n);
    logic [31:0] cur;
    int          len;
    case ($urandom_range(0, 5))
      0: cur = 0;
      1: cur = 32'h7FFF_0000 + $urandom_range(0, 255);
      default: cur = $urandom_range(0, 32'h7FF0_0000);
    endcase
    for (int k = 0; k < n; k++) begin
      len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
      gene_first[k] = POS_W'(cur);
      if ($urandom_range(0, 15) == 0) gene_end[k] = POS_W'(cur - $urandom_range(0, 3));
      else gene_end[k] = POS_W'(cur + len);
      if ($urandom_range(0, 9) == 0) cur = cur + $urandom_range(0, len);
      else cur = cur + len + $urandom_range(0, 24);
    end
  endfunction

  // Positions cluster around exon edges, with some anywhere at all
  function automatic logic [POS_W-1:0] pick_position(input int n);
    int k;
    int roll;
    if (n == 0) return POS_W'($urandom);
    k = $urandom_range(0, n - 1);
    roll = $urandom_range(0, 9);
    if (roll < 4) return POS_W'(gene_first[k] + $urandom_range(0, 5) - 2);
    if (roll < 7) return POS_W'(gene_end[k] + $urandom_range(0, 5) - 4);
    if (roll < 8) return POS_W'(gene_first[k] + $urandom_range(0, 30));
    if (roll < 9) return POS_W'(gene_end[n - 1] + $urandom_range(0, 3));
    return POS_W'($urandom);
  endfunction

  // Returns once all queued transactions are accepted and all results seen
  task automatic wait_results();
    while (pending_q.size() != 0 || in_done_cnt != in_sent_cnt ||
           region_expect_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_STRAND) strand_fwd = value[0];
    else exon_num = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Idle the block fully before touching a register
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver: holds each transaction until accepted, then maybe a gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_done_cnt != in_sent_cnt) begin
      // still waiting for the handshake
    end else if (in_idle > 0) begin
      in_valid <= 1'b0;
      in_idle <= in_idle - 1;
    end else if (pending_q.size() > 0) begin
      item_t it;
      it = pending_q.pop_front();
      in_mode <= it.mode;
      in_entry_index <= it.slot;
      in_entry_start <= it.exon_first;
      in_entry_end <= it.exon_end;
      in_query_position <= it.position;
      in_valid <= 1'b1;
      in_sent_cnt <= in_sent_cnt + 1;
      in_idle <= gap_cycles();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result side backpressure
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      out_hold <= gap_cycles();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on input transactions, check result transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_done_cnt <= in_done_cnt + 1;
        if (in_mode == MODE_LOAD) begin
          exon_start_mem[in_entry_index] = in_entry_start;
          exon_end_mem[in_entry_index] = in_entry_end;
        end else begin
          region_expect_q.insert(region_expect_q.size(),
                                 classify_position(in_query_position));
        end
      end
      if (out_valid && out_ready) begin
        if (region_expect_q.size() == 0) begin
          $error("result with no query outstanding: kind %0d number %0d",
                 out_region_kind, out_region_number);
          err_cnt++;
        end else begin
          region_t want;
          want = region_expect_q.pop_front();
          if (out_region_kind !== want.kind) begin
            $error("region_kind: expected %0d, got %0d", want.kind, out_region_kind);
            err_cnt++;
          end
          if (out_region_number !== want.number) begin
            $error("region_number: expected %0d, got %0d", want.number, out_region_number);
            err_cnt++;
          end
          if (out_splice_acceptor !== want.acceptor) begin
            $error("splice_acceptor: expected %0d, got %0d", want.acceptor,
                   out_splice_acceptor);
            err_cnt++;
          end
          if (out_splice_donor !== want.donor) begin
            $error("splice_donor: expected %0d, got %0d", want.donor, out_splice_donor);
            err_cnt++;
          end
        end
      end
      // watchdog on any channel making progress
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("splice_site_region_classifier_unit_test NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus
  initial begin
    int count, n, nq, k, phase;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table at reset values
    push_query('0);
    push_query(31'h7FFF_FFFF);
    settle();

    // Directed: three exons, forward strand
    write_register(CFG_STRAND, 1);
    write_register(CFG_COUNT, 3);
    push_load(0, 0, 10);
    push_load(1, 20, 30);
    push_load(2, 40, 31'h7FFF_FFFF);
    push_load(TABLE_DEPTH - 1, 31'h7FFF_FFFF, 0);
    push_query(0);
    push_query(7);
    push_query(10);
    push_query(11);
    push_query(18);
    push_query(19);
    push_query(20);
    push_query(29);
    push_query(39);
    push_query(31'h7FFF_FFFE);
    push_query(31'h7FFF_FFFF);
    settle();

    // Directed: same table on the reverse strand, then an overlapping exon
    write_register(CFG_STRAND, 0);
    push_query(9);
    push_query(10);
    push_query(19);
    push_query(38);
    push_query(40);
    push_query(42);
    push_load(1, 5, 45);
    push_query(5);
    push_query(12);
    push_query(44);

    // Random phases, each with its own strand, count and gene
    phase = 0;
    while (items_made < ITEM_TARGET) begin
      case (phase)
        2: count = TABLE_DEPTH;
        5: count = 127;
        9: count = 0;
        12: count = 1;
        default: count = ($urandom_range(0, 5) == 0) ? $urandom_range(9, TABLE_DEPTH)
                                                       : $urandom_range(2, 8);
      endcase
      n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
      settle();
      calm = ($urandom_range(0, 3) == 0);
      write_register(CFG_STRAND, CNT_W'($urandom_range(0, 1)));
      write_register(CFG_COUNT, CNT_W'(count));
      plan_gene(n);
      for (int s = 0; s < n; s++) begin
        k = (phase % 2 == 0) ? s : n - 1 - s;
        push_load(k, gene_first[k], gene_end[k]);
      end
      nq = $urandom_range(20, 40);
      for (int q = 0; q < nq; q++) begin
        // in every third phase the sender holds off halfway until every result is back
        if (q == nq / 2 && phase % 3 == 0) wait_results();
        if ($urandom_range(0, 9) == 0) begin
          k = $urandom_range(0, TABLE_DEPTH - 1);
          if (k < n) begin
            gene_first[k] = POS_W'(gene_first[k] + $urandom_range(0, 4) - 2);
            gene_end[k] = POS_W'(gene_end[k] + $urandom_range(0, 4) - 2);
            push_load(k, gene_first[k], gene_end[k]);
          end else begin
            push_load(k, POS_W'($urandom), POS_W'($urandom));
          end
        end else begin
          push_query(pick_position(n));
        end
      end
      phase++;
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (region_expect_q.size() != 0) begin
      $error("%0d results never arrived", region_expect_q.size());
    end
    if (err_cnt == 0 && region_expect_q.size() == 0) begin
      $display("splice_site_region_classifier_unit_test OK");
    end else begin
      $display("splice_site_region_classifier_unit_test NOT OK");
    end
    $finish;
  end

endmodule
